// File: hdl/cpd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared widths, defaults and sequencer states of the point to convex
// polygon distance block.
// ----------------------------------------------------------------------------
package cpd_pkg;

  localparam int CoordW   = 16;  // signed Q8.8 coordinate
  localparam int DiffW    = 17;  // difference of two coordinates
  localparam int ProdW    = 34;  // product of two differences
  localparam int SumW     = 35;  // sum of two products
  localparam int NumW     = 33;  // projection numerator when 0 < num < den
  localparam int MagW     = 16;  // magnitude of an edge component
  localparam int DivNW    = MagW + NumW;
  localparam int QuotW    = 16;
  localparam int RootW    = 18;
  localparam int DistW    = 17;
  localparam int CountW   = 5;
  localparam int IndexW   = 4;
  localparam int MinCount = 3;

  localparam int MAX_VERTICES_DEF = 16;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD0,
    ST_EDGE_A,
    ST_EDGE_M,
    ST_EDGE_S,
    ST_EDGE_P,
    ST_EDGE_W,
    ST_EDGE_Q,
    ST_EDGE_QM,
    ST_EDGE_QS,
    ST_FINAL,
    ST_SQRT,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// File: hdl/convex_polygon_point_distance.sv
`default_nettype none
// ----------------------------------------------------------------------------
// convex_polygon_point_distance
// Distance from a query point to a convex polygon held in a vertex memory.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): req_type 0 writes coord_x/coord_y to
// slot vertex_index and gives no result; req_type 1 is a query and gives
// exactly one beat on the output channel (out_valid / out_stall).
// Configuration (cfg_valid / cfg_ready): cfg_data sets vertex_count, always
// ready; write it only while the block is idle.
// A query walks the n vertices through the single read port of the vertex
// memory, one edge at a time: an edge whose projection is clamped skips the
// divider, one whose projection falls inside the edge waits for the 16-step
// divider, and a point outside ends with the 18-step square root. A load
// leaves the block idle, so the next item can follow it. While a query
// runs, in_stall is high.
// The result sits in an output register; the next item is taken while it
// waits, and a finished query holds until out_stall drops.
// Reset clears the control state and sets vertex_count to 3; the vertex
// memory is not cleared, so every slot in use must be loaded first.
// ----------------------------------------------------------------------------
module convex_polygon_point_distance #(
  parameter int MAX_VERTICES = cpd_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              req_type,
  input  wire logic [cpd_pkg::IndexW-1:0]        vertex_index,
  input  wire logic signed [cpd_pkg::CoordW-1:0] coord_x,
  input  wire logic signed [cpd_pkg::CoordW-1:0] coord_y,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [cpd_pkg::CountW-1:0]        cfg_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   inside_res,
  output logic [cpd_pkg::DistW-1:0]              dist_res,
  output logic signed [cpd_pkg::CoordW-1:0]      closest_x,
  output logic signed [cpd_pkg::CoordW-1:0]      closest_y
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int W  = cpd_pkg::CoordW;
  localparam int DW = cpd_pkg::DiffW;
  localparam int PW = cpd_pkg::ProdW;
  localparam int SW = cpd_pkg::SumW;

  cpd_pkg::state_t state, state_next;

  logic [cpd_pkg::CountW-1:0] vertex_count;

  // vertex memory, x in the low half
  logic [2*W-1:0] mem [MAX_VERTICES];
  logic [2*W-1:0] rdata;
  logic [AW-1:0]  raddr;
  logic           accept;
  logic           load_we;

  logic [CW-1:0] n_eff;
  logic [CW-1:0] k;
  logic [CW-1:0] k_inc;

  logic signed [W-1:0]  px, py, ax, ay, bx, by;
  logic signed [DW-1:0] ex, ey, dax, day;
  logic signed [PW-1:0] m_sx, m_sy, m_nx, m_ny, m_ex, m_ey, m_ax, m_ay;
  logic signed [SW-1:0] s_num, s_den;
  logic [cpd_pkg::MagW-1:0] mag_x, mag_y;
  logic [cpd_pkg::DivNW-1:0] dvd_x, dvd_y;
  logic [cpd_pkg::QuotW-1:0] quo_x, quo_y;
  logic div_start, div_done_x, div_done_y;
  logic signed [DW-1:0] qx, qy, dqx, dqy;
  logic signed [PW-1:0] sq_x, sq_y;
  logic [SW-1:0] d_edge;

  logic in_poly;
  logic [SW-1:0] vbest, ebest;
  logic signed [W-1:0] vbx, vby, ebx, eby;

  logic sqrt_start, sqrt_done;
  logic [cpd_pkg::RootW-1:0] root;
  logic [SW-1:0] best_d;
  logic use_edge;

  logic res_in;
  logic [cpd_pkg::DistW-1:0] res_d;
  logic signed [W-1:0] res_x, res_y;

  logic signed [SW-1:0] s_side, s_n, s_d;

  assign accept    = in_valid && !in_stall;
  assign load_we   = accept && (req_type == cpd_pkg::REQ_LOAD)
                     && (32'(vertex_index) < MAX_VERTICES);
  assign cfg_ready = 1'b1;
  assign k_inc     = k + CW'(1);
  assign use_edge  = ebest < vbest;
  assign best_d    = use_edge ? ebest : vbest;

  always_comb begin
    if (vertex_count < cpd_pkg::CountW'(cpd_pkg::MinCount)) begin
      n_eff = CW'(cpd_pkg::MinCount);
    end else if (32'(vertex_count) > MAX_VERTICES) begin
      n_eff = CW'(MAX_VERTICES);
    end else begin
      n_eff = CW'(vertex_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= cpd_pkg::CountW'(cpd_pkg::MinCount);
    end else if (cfg_valid && cfg_ready) begin
      vertex_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      mem[AW'(vertex_index)] <= {coord_y, coord_x};
    end
    rdata <= mem[raddr];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      cpd_pkg::ST_IDLE: begin
        if (accept && req_type == cpd_pkg::REQ_QUERY) state_next = cpd_pkg::ST_LOAD0;
      end
      cpd_pkg::ST_LOAD0:   state_next = cpd_pkg::ST_EDGE_A;
      cpd_pkg::ST_EDGE_A:  state_next = cpd_pkg::ST_EDGE_M;
      cpd_pkg::ST_EDGE_M:  state_next = cpd_pkg::ST_EDGE_S;
      cpd_pkg::ST_EDGE_S: begin
        if (s_d == '0 || s_n <= SW'(0) || s_n >= s_d) state_next = cpd_pkg::ST_EDGE_Q;
        else state_next = cpd_pkg::ST_EDGE_P;
      end
      cpd_pkg::ST_EDGE_P:  state_next = cpd_pkg::ST_EDGE_W;
      cpd_pkg::ST_EDGE_W: begin
        if (div_done_x) state_next = cpd_pkg::ST_EDGE_Q;
      end
      cpd_pkg::ST_EDGE_Q:  state_next = cpd_pkg::ST_EDGE_QM;
      cpd_pkg::ST_EDGE_QM: state_next = cpd_pkg::ST_EDGE_QS;
      cpd_pkg::ST_EDGE_QS: begin
        if (k == n_eff) state_next = cpd_pkg::ST_FINAL;
        else state_next = cpd_pkg::ST_EDGE_A;
      end
      cpd_pkg::ST_FINAL: begin
        if (in_poly) state_next = cpd_pkg::ST_DONE;
        else state_next = cpd_pkg::ST_SQRT;
      end
      cpd_pkg::ST_SQRT: begin
        if (sqrt_done) state_next = cpd_pkg::ST_DONE;
      end
      cpd_pkg::ST_DONE: begin
        if (!(out_valid && out_stall)) state_next = cpd_pkg::ST_IDLE;
      end
      default: state_next = cpd_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall   = (state != cpd_pkg::ST_IDLE);
    raddr      = '0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    case (state)
      cpd_pkg::ST_LOAD0:   raddr = AW'(1);
      cpd_pkg::ST_EDGE_P:  div_start = 1'b1;
      cpd_pkg::ST_EDGE_QS: raddr = (k_inc == n_eff) ? '0 : AW'(k_inc);
      cpd_pkg::ST_FINAL:   sqrt_start = !in_poly;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= cpd_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    s_side = SW'(m_sx) - SW'(m_sy);
    s_n    = SW'(m_nx) + SW'(m_ny);
    s_d    = SW'(m_ex) + SW'(m_ey);
  end

  // dividends feed the dividers directly, sampled on the start cycle
  assign dvd_x = cpd_pkg::DivNW'(mag_x) * cpd_pkg::DivNW'(s_num[cpd_pkg::NumW-1:0]);
  assign dvd_y = cpd_pkg::DivNW'(mag_y) * cpd_pkg::DivNW'(s_num[cpd_pkg::NumW-1:0]);

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      cpd_pkg::ST_IDLE: begin
        if (accept) begin
          px      <= coord_x;
          py      <= coord_y;
          in_poly <= 1'b1;
        end
      end
      cpd_pkg::ST_LOAD0: begin
        ax <= rdata[W-1:0];
        ay <= rdata[2*W-1:W];
        k  <= CW'(1);
      end
      cpd_pkg::ST_EDGE_A: begin
        bx  <= rdata[W-1:0];
        by  <= rdata[2*W-1:W];
        ex  <= DW'(signed'(rdata[W-1:0])) - DW'(ax);
        ey  <= DW'(signed'(rdata[2*W-1:W])) - DW'(ay);
        dax <= DW'(px) - DW'(ax);
        day <= DW'(py) - DW'(ay);
      end
      cpd_pkg::ST_EDGE_M: begin
        m_sx <= dax * ey;
        m_sy <= day * ex;
        m_nx <= dax * ex;
        m_ny <= day * ey;
        m_ex <= ex * ex;
        m_ey <= ey * ey;
        m_ax <= dax * dax;
        m_ay <= day * day;
      end
      cpd_pkg::ST_EDGE_S: begin
        s_num <= s_n;
        s_den <= s_d;
        if (s_side > SW'(0)) in_poly <= 1'b0;
        if (k == CW'(1) || (SW'(m_ax) + SW'(m_ay)) < vbest) begin
          vbest <= SW'(m_ax) + SW'(m_ay);
          vbx   <= ax;
          vby   <= ay;
        end
        if (s_d == '0 || s_n <= SW'(0)) begin
          qx <= DW'(ax);
          qy <= DW'(ay);
        end else begin
          qx <= DW'(bx);
          qy <= DW'(by);
        end
        mag_x <= ex[DW-1] ? cpd_pkg::MagW'(-ex) : cpd_pkg::MagW'(ex);
        mag_y <= ey[DW-1] ? cpd_pkg::MagW'(-ey) : cpd_pkg::MagW'(ey);
      end
      cpd_pkg::ST_EDGE_W: begin
        if (div_done_x) begin
          qx <= ex[DW-1] ? DW'(ax) - DW'(quo_x) : DW'(ax) + DW'(quo_x);
          qy <= ey[DW-1] ? DW'(ay) - DW'(quo_y) : DW'(ay) + DW'(quo_y);
        end
      end
      cpd_pkg::ST_EDGE_Q: begin
        dqx <= DW'(px) - qx;
        dqy <= DW'(py) - qy;
      end
      cpd_pkg::ST_EDGE_QM: begin
        sq_x <= dqx * dqx;
        sq_y <= dqy * dqy;
      end
      cpd_pkg::ST_EDGE_QS: begin
        if (k == CW'(1) || d_edge < ebest) begin
          ebest <= d_edge;
          ebx   <= W'(qx);
          eby   <= W'(qy);
        end
        ax <= bx;
        ay <= by;
        k  <= k_inc;
      end
      cpd_pkg::ST_FINAL: begin
        res_in <= in_poly;
        if (in_poly) begin
          res_d <= '0;
          res_x <= px;
          res_y <= py;
        end else begin
          res_x <= use_edge ? ebx : vbx;
          res_y <= use_edge ? eby : vby;
        end
      end
      cpd_pkg::ST_SQRT: begin
        if (sqrt_done) res_d <= root[cpd_pkg::DistW-1:0];
      end
      default: ;
    endcase
  end

  assign d_edge = SW'(unsigned'(sq_x)) + SW'(unsigned'(sq_y));

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == cpd_pkg::ST_DONE && !(out_valid && out_stall)) begin
      out_valid  <= 1'b1;
      inside_res <= res_in;
      dist_res   <= res_d;
      closest_x  <= res_x;
      closest_y  <= res_y;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  cpd_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd_x),
    .divisor  (s_den[cpd_pkg::NumW-1:0]),
    .quot     (quo_x),
    .done     (div_done_x)
  );

  cpd_div u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start && !div_done_y),
    .dividend (dvd_y),
    .divisor  (s_den[cpd_pkg::NumW-1:0]),
    .quot     (quo_y),
    .done     (div_done_y)
  );

  cpd_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (best_d),
    .root     (root),
    .done     (sqrt_done)
  );

endmodule

`default_nettype wire

// File: hdl/cpd_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpd_div
// Restoring divider, one quotient bit a cycle. The caller guarantees the
// quotient fits in QuotW bits (dividend < divisor << QuotW).
// ----------------------------------------------------------------------------
module cpd_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [cpd_pkg::DivNW-1:0]   dividend,
  input  wire logic [cpd_pkg::NumW-1:0]    divisor,
  output logic      [cpd_pkg::QuotW-1:0]   quot,
  output logic                             done
);

  localparam int NW = cpd_pkg::NumW;
  localparam int QW = cpd_pkg::QuotW;

  logic [NW-1:0]         rem;
  logic [QW-1:0]         sh;
  logic [$clog2(QW+1)-1:0] cnt;
  logic                  busy;
  logic [NW:0]           trial;

  assign trial = {rem, sh[QW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= dividend[cpd_pkg::DivNW-1:QW];
        sh   <= dividend[QW-1:0];
        cnt  <= ($clog2(QW+1))'(QW);
        busy <= 1'b1;
      end else if (busy) begin
        if (trial >= {1'b0, divisor}) begin
          rem  <= NW'(trial - {1'b0, divisor});
          quot <= {quot[QW-2:0], 1'b1};
        end else begin
          rem  <= trial[NW-1:0];
          quot <= {quot[QW-2:0], 1'b0};
        end
        sh  <= {sh[QW-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == ($clog2(QW+1))'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/cpd_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpd_sqrt
// Digit-by-digit integer square root, one root bit a cycle, floor result.
// ----------------------------------------------------------------------------
module cpd_sqrt (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [cpd_pkg::SumW-1:0]   radicand,
  output logic      [cpd_pkg::RootW-1:0]  root,
  output logic                            done
);

  localparam int RW = cpd_pkg::RootW;
  localparam int VW = 2 * RW;
  localparam int RemW = RW + 4;

  logic [VW-1:0]           sh;
  logic [RemW-1:0]         rem;
  logic [$clog2(RW+1)-1:0] cnt;
  logic                    busy;
  logic [RemW-1:0]         rem_sh;
  logic [RemW-1:0]         trial;

  assign rem_sh = {rem[RemW-3:0], sh[VW-1:VW-2]};
  assign trial  = RemW'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        sh   <= VW'(radicand);
        rem  <= '0;
        root <= '0;
        cnt  <= ($clog2(RW+1))'(RW);
        busy <= 1'b1;
      end else if (busy) begin
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[RW-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[RW-2:0], 1'b0};
        end
        sh  <= {sh[VW-3:0], 2'b00};
        cnt <= cnt - 1'b1;
        if (cnt == ($clog2(RW+1))'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: tb/cpd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_checker
// Watches the input, configuration and result channels of the polygon
// distance block, predicts each query result and compares it field by field.
// ----------------------------------------------------------------------------
module cpd_checker (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  input  wire logic                              in_stall,
  input  wire logic                              req_type,
  input  wire logic [cpd_pkg::IndexW-1:0]        vertex_index,
  input  wire logic signed [cpd_pkg::CoordW-1:0] coord_x,
  input  wire logic signed [cpd_pkg::CoordW-1:0] coord_y,
  input  wire logic                              cfg_valid,
  input  wire logic                              cfg_ready,
  input  wire logic [cpd_pkg::CountW-1:0]        cfg_data,
  input  wire logic                              out_valid,
  input  wire logic                              out_stall,
  input  wire logic                              inside_res,
  input  wire logic [cpd_pkg::DistW-1:0]         dist_res,
  input  wire logic signed [cpd_pkg::CoordW-1:0] closest_x,
  input  wire logic signed [cpd_pkg::CoordW-1:0] closest_y,
  output int                                     fail_count,
  output int                                     pending
);

  typedef struct packed {
    logic                      inner;
    logic [cpd_pkg::DistW-1:0] dist_q;
    logic [15:0]               cx;
    logic [15:0]               cy;
  } answer_t;

  answer_t     answers[$];
  longint      poly_x[16];
  longint      poly_y[16];
  logic [cpd_pkg::CountW-1:0] vcount;

  assign pending = answers.size();

  function automatic longint root_floor(longint v);
    longint r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic answer_t nearest_point(longint px, longint py);
    answer_t a;
    int n, j;
    longint ex, ey, s, num, den, qx, qy, d, best, cx, cy;
    bit is_in;
    n = (vcount < 3) ? 3 : ((vcount > 16) ? 16 : vcount);
    is_in = 1;
    for (int i = 0; i < n; i++) begin
      j = (i + 1 == n) ? 0 : i + 1;
      ex = poly_x[j] - poly_x[i];
      ey = poly_y[j] - poly_y[i];
      s = (px - poly_x[i]) * ey - (py - poly_y[i]) * ex;
      if (s > 0) is_in = 0;
    end
    if (is_in) begin
      a.inner = 1;
      a.dist_q = '0;
      a.cx = px[15:0];
      a.cy = py[15:0];
      return a;
    end
    cx = poly_x[0];
    cy = poly_y[0];
    best = (px - cx) * (px - cx) + (py - cy) * (py - cy);
    for (int i = 1; i < n; i++) begin
      d = (px - poly_x[i]) ** 2 + (py - poly_y[i]) ** 2;
      if (d < best) begin
        best = d; cx = poly_x[i]; cy = poly_y[i];
      end
    end
    for (int i = 0; i < n; i++) begin
      j = (i + 1 == n) ? 0 : i + 1;
      ex = poly_x[j] - poly_x[i];
      ey = poly_y[j] - poly_y[i];
      num = (px - poly_x[i]) * ex + (py - poly_y[i]) * ey;
      den = ex * ex + ey * ey;
      if (den == 0 || num <= 0) begin
        qx = poly_x[i]; qy = poly_y[i];
      end else if (num >= den) begin
        qx = poly_x[j]; qy = poly_y[j];
      end else begin
        // SV signed division truncates toward zero
        qx = poly_x[i] + (ex * num) / den;
        qy = poly_y[i] + (ey * num) / den;
      end
      d = (px - qx) * (px - qx) + (py - qy) * (py - qy);
      if (d < best) begin
        best = d; cx = qx; cy = qy;
      end
    end
    a.inner = 0;
    a.dist_q = cpd_pkg::DistW'(root_floor(best));
    a.cx = cx[15:0];
    a.cy = cy[15:0];
    return a;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  always @(posedge clk) begin
    answer_t w;
    if (rst) begin
      vcount <= 5'd3;
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) vcount <= cfg_data;
      if (in_valid && !in_stall) begin
        if (req_type == cpd_pkg::REQ_LOAD) begin
          poly_x[vertex_index] = longint'(coord_x);
          poly_y[vertex_index] = longint'(coord_y);
        end else begin
          answers = {answers, nearest_point(longint'(coord_x), longint'(coord_y))};
        end
      end
      if (out_valid && !out_stall) begin
        if (answers.size() == 0) begin
          report("unexpected beat", 0, 0);
        end else begin
          w = answers.pop_front();
          if (inside_res !== w.inner) report("inside_res", inside_res, w.inner);
          if (dist_res !== w.dist_q) report("dist_res", dist_res, w.dist_q);
          if (closest_x !== w.cx) report("closest_x", closest_x, w.cx);
          if (closest_y !== w.cy) report("closest_y", closest_y, w.cy);
        end
      end
    end
  end
endmodule

// File: tb/tb_convex_polygon_point_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_convex_polygon_point_distance
// Loads random convex polygons of several sizes, sends directed and random
// query points with random gaps and output stalls, and relies on the checker
// for prediction and comparison.
// ----------------------------------------------------------------------------
module tb_convex_polygon_point_distance;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall, req_type = 0;
  logic [cpd_pkg::IndexW-1:0] vertex_index = '0;
  logic signed [cpd_pkg::CoordW-1:0] coord_x = '0, coord_y = '0;
  logic cfg_valid = 0, cfg_ready;
  logic [cpd_pkg::CountW-1:0] cfg_data = '0;
  logic out_valid, out_stall = 0, inside_res;
  logic [cpd_pkg::DistW-1:0] dist_res;
  logic signed [cpd_pkg::CoordW-1:0] closest_x, closest_y;
  int fail_count, pending, idle_cycles;
  bit send_gaps = 1, sink_gaps = 1, hold_sink = 0;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  convex_polygon_point_distance dut (.*);
  cpd_checker chk (.*);

  // no-progress watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("tb_convex_polygon_point_distance: done, errors");
      $finish;
    end
  end

  // receiver stall bursts; one long hold when asked
  initial begin
    bit held;
    held = 0;
    @(negedge clk);
    forever begin
      if (hold_sink && !held) begin
        held = 1;
        out_stall <= 1;
        repeat (2000) @(negedge clk);
      end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end else begin
        out_stall <= 0;
        @(negedge clk);
      end
    end
  end

  // leaves in_valid high; drain and set_count drop it
  task automatic send(logic rt, logic [3:0] idx, logic [15:0] x, logic [15:0] y);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1;
    req_type <= rt;
    vertex_index <= idx;
    coord_x <= x;
    coord_y <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_count(logic [4:0] n);
    in_valid <= 0;
    cfg_valid <= 1;
    cfg_data <= n;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // regular polygon-ish convex shape: points on a circle, CCW
  task automatic load_poly(int n, int rad, int ox, int oy);
    real a;
    for (int i = 0; i < 16; i++) begin
      a = 6.283185307 * (i % n) / n + 0.1;
      send(cpd_pkg::REQ_LOAD, i[3:0], 16'(ox + $rtoi(rad * $cos(a))),
           16'(oy + $rtoi(rad * $sin(a))));
    end
  endtask

  task automatic query_random(int span);
    if ($urandom_range(0, 9) == 0)
      send(cpd_pkg::REQ_QUERY, 4'($urandom), 16'($urandom), 16'($urandom));
    else
      send(cpd_pkg::REQ_QUERY, 4'($urandom), 16'($signed($urandom_range(0, 2 * span)) - span),
           16'($signed($urandom_range(0, 2 * span)) - span));
  endtask

  initial begin
    int counts[6] = '{3, 16, 4, 7, 12, 31};
    repeat (6) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // directed: tiny triangle at reset count, extreme points, degenerate edges
    send(cpd_pkg::REQ_LOAD, 4'd0, 16'sd0, 16'sd0);
    send(cpd_pkg::REQ_LOAD, 4'd1, 16'sd256, 16'sd0);
    send(cpd_pkg::REQ_LOAD, 4'd2, 16'sd0, 16'sd256);
    send(cpd_pkg::REQ_QUERY, 4'd0, 16'sd10, 16'sd10);
    send(cpd_pkg::REQ_QUERY, 4'd0, 16'sd0, 16'sd0);
    send(cpd_pkg::REQ_QUERY, 4'd0, 16'sd128, 16'sd128);
    send(cpd_pkg::REQ_QUERY, 4'd15, 16'h8000, 16'h8000);
    send(cpd_pkg::REQ_QUERY, 4'd0, 16'h7fff, 16'h7fff);
    send(cpd_pkg::REQ_QUERY, 4'd0, 16'h7fff, 16'h8000);
    send(cpd_pkg::REQ_QUERY, 4'd0, 16'sd500, -16'sd20);
    drain();
    // full-range quad with a repeated vertex for a zero-length edge
    send(cpd_pkg::REQ_LOAD, 4'd0, 16'h8000, 16'h8000);
    send(cpd_pkg::REQ_LOAD, 4'd1, 16'h7fff, 16'h8000);
    send(cpd_pkg::REQ_LOAD, 4'd2, 16'h7fff, 16'h7fff);
    send(cpd_pkg::REQ_LOAD, 4'd3, 16'h7fff, 16'h7fff);
    set_count(5'd4);
    drain();
    send(cpd_pkg::REQ_QUERY, 4'd0, 16'sd0, 16'sd0);
    send(cpd_pkg::REQ_QUERY, 4'd0, 16'h8000, 16'h7fff);
    send(cpd_pkg::REQ_QUERY, 4'd0, 16'h7000, 16'h9000);
    drain();
    for (int i = 0; i < 16; i++) send(cpd_pkg::REQ_LOAD, 4'(i), 16'($urandom), 16'($urandom));
    set_count(5'd0);
    drain();
    send(cpd_pkg::REQ_QUERY, 4'd0, 16'sd7, -16'sd7);
    drain();
    set_count(5'd16);
    send(cpd_pkg::REQ_QUERY, 4'd0, 16'sd300, -16'sd300);
    drain();
    // random phases over several counts
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      set_count(5'(counts[ph]));
      load_poly(counts[ph] < 3 ? 3 : (counts[ph] > 16 ? 16 : counts[ph]),
                $urandom_range(50, 20000), $urandom_range(0, 4000) - 2000,
                $urandom_range(0, 4000) - 2000);
      if (ph == 1) begin
        hold_sink = 1;
        for (int k = 0; k < 10; k++) query_random(30000);
        drain();
      end
      if (ph == 5) begin
        send_gaps = 0;
        sink_gaps = 0;
      end
      for (int k = 0; k < 200; k++) query_random($urandom_range(0, 1) ? 32767 : 3000);
    end
    drain();
    if (fail_count == 0) begin
      $display("tb_convex_polygon_point_distance: done, clean");
    end else begin
      $display("tb_convex_polygon_point_distance: done, errors");
    end
    $finish;
  end
endmodule
